// ===== rtl/chip8_instruction_core_defines.svh =====
// Assertion macros used by the checker file of the core.
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C8IC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define C8IC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/c8ic_pkg.sv =====
// Types, constants and font table shared by the CHIP-8 instruction core.
package c8ic_pkg;

    localparam int MEM_DEPTH       = 4096;
    localparam int MEM_AW          = 12;
    localparam int SCREEN_WIDTH    = 64;
    localparam int SCREEN_HEIGHT   = 32;
    localparam int ROW_AW          = 5;
    localparam int REG_COUNT       = 16;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [11:0] FONT_BASE  = 12'h050;
    localparam logic [11:0] PROG_START = 12'h200;
    localparam logic [11:0] FONT_LAST  = 12'h09F;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [7:0] NN_SKP      = 8'h9E;
    localparam logic [7:0] NN_SKNP     = 8'hA1;
    localparam logic [7:0] NN_GET_DLY  = 8'h07;
    localparam logic [7:0] NN_KEY_WAIT = 8'h0A;
    localparam logic [7:0] NN_SET_DLY  = 8'h15;
    localparam logic [7:0] NN_SET_SND  = 8'h18;
    localparam logic [7:0] NN_ADD_I    = 8'h1E;
    localparam logic [7:0] NN_FONT     = 8'h29;
    localparam logic [7:0] NN_BCD      = 8'h33;
    localparam logic [7:0] NN_DUMP     = 8'h55;
    localparam logic [7:0] NN_LOAD     = 8'h65;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_UNDER = 2'd1;
    localparam logic [1:0] FAULT_OVER  = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_PIXEL = 2'd2,
        CMD_EXEC  = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        DP_IDLE,
        DP_INIT,
        DP_ACCESS,
        DP_FETCH0,
        DP_FETCH1,
        DP_FETCH2,
        DP_RDX,
        DP_RDY,
        DP_EXEC,
        DP_WB,
        DP_CLS,
        DP_SPR_RD,
        DP_SPR_WR,
        DP_SPR_FLAG,
        DP_BCD,
        DP_DUMP_RD,
        DP_DUMP_WR,
        DP_LOAD_RD,
        DP_LOAD_WR,
        DP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   latch;
    } t_dp_cmd;

    typedef struct packed {
        logic init_last;
        logic cmd_exec;
        logic wr_vx;
        logic is_cls;
        logic is_draw;
        logic draw_empty;
        logic is_bcd;
        logic is_dump;
        logic is_load;
        logic cls_last;
        logic spr_last;
        logic bcd_last;
        logic xfer_last;
    } t_dp_stat;

    localparam logic [7:0] FONT [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // Reset image of main memory: font glyphs in their window, zero elsewhere.
    function automatic logic [7:0] init_byte(input logic [11:0] addr);
        logic [11:0] off;
        off = addr - FONT_BASE;
        if (addr >= FONT_BASE && addr <= FONT_LAST) begin
            return FONT[off[6:0]];
        end
        return 8'h00;
    endfunction

endpackage

// ===== rtl/c8ic_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module c8ic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/c8ic_ctrl.sv =====
// Sequencer of the CHIP-8 core: command handshake, fetch, execute and loops.
module c8ic_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  c8ic_pkg::t_dp_stat i_stat,
    output c8ic_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_done
);

    typedef enum logic [19:0] {
        S_INIT     = 20'h00001,
        S_IDLE     = 20'h00002,
        S_ACCESS   = 20'h00004,
        S_FETCH0   = 20'h00008,
        S_FETCH1   = 20'h00010,
        S_FETCH2   = 20'h00020,
        S_RDX      = 20'h00040,
        S_RDY      = 20'h00080,
        S_EXEC     = 20'h00100,
        S_WB       = 20'h00200,
        S_CLS      = 20'h00400,
        S_SPR_RD   = 20'h00800,
        S_SPR_WR   = 20'h01000,
        S_SPR_FLAG = 20'h02000,
        S_BCD      = 20'h04000,
        S_DUMP_RD  = 20'h08000,
        S_DUMP_WR  = 20'h10000,
        S_LOAD_RD  = 20'h20000,
        S_LOAD_WR  = 20'h40000,
        S_FINISH   = 20'h80000
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    always_comb begin
        n_state      = r_state;
        o_cmd.latch  = 1'b0;
        o_cmd.op     = c8ic_pkg::DP_IDLE;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = c8ic_pkg::DP_INIT;
                if (i_stat.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_ACCESS;
                end
            end
            S_ACCESS: begin
                o_cmd.op = c8ic_pkg::DP_ACCESS;
                n_state  = i_stat.cmd_exec ? S_FETCH0 : S_FINISH;
            end
            S_FETCH0: begin
                o_cmd.op = c8ic_pkg::DP_FETCH0;
                n_state  = S_FETCH1;
            end
            S_FETCH1: begin
                o_cmd.op = c8ic_pkg::DP_FETCH1;
                n_state  = S_FETCH2;
            end
            S_FETCH2: begin
                o_cmd.op = c8ic_pkg::DP_FETCH2;
                n_state  = S_RDX;
            end
            S_RDX: begin
                o_cmd.op = c8ic_pkg::DP_RDX;
                n_state  = S_RDY;
            end
            S_RDY: begin
                o_cmd.op = c8ic_pkg::DP_RDY;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.op = c8ic_pkg::DP_EXEC;
                priority if (i_stat.is_cls) begin
                    n_state = S_CLS;
                end else if (i_stat.is_draw) begin
                    n_state = i_stat.draw_empty ? S_SPR_FLAG : S_SPR_RD;
                end else if (i_stat.is_bcd) begin
                    n_state = S_BCD;
                end else if (i_stat.is_dump) begin
                    n_state = S_DUMP_RD;
                end else if (i_stat.is_load) begin
                    n_state = S_LOAD_RD;
                end else if (i_stat.wr_vx) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_WB: begin
                o_cmd.op = c8ic_pkg::DP_WB;
                n_state  = S_FINISH;
            end
            S_CLS: begin
                o_cmd.op = c8ic_pkg::DP_CLS;
                if (i_stat.cls_last) n_state = S_FINISH;
            end
            S_SPR_RD: begin
                o_cmd.op = c8ic_pkg::DP_SPR_RD;
                n_state  = S_SPR_WR;
            end
            S_SPR_WR: begin
                o_cmd.op = c8ic_pkg::DP_SPR_WR;
                n_state  = i_stat.spr_last ? S_SPR_FLAG : S_SPR_RD;
            end
            S_SPR_FLAG: begin
                o_cmd.op = c8ic_pkg::DP_SPR_FLAG;
                n_state  = S_FINISH;
            end
            S_BCD: begin
                o_cmd.op = c8ic_pkg::DP_BCD;
                if (i_stat.bcd_last) n_state = S_FINISH;
            end
            S_DUMP_RD: begin
                o_cmd.op = c8ic_pkg::DP_DUMP_RD;
                n_state  = S_DUMP_WR;
            end
            S_DUMP_WR: begin
                o_cmd.op = c8ic_pkg::DP_DUMP_WR;
                n_state  = i_stat.xfer_last ? S_FINISH : S_DUMP_RD;
            end
            S_LOAD_RD: begin
                o_cmd.op = c8ic_pkg::DP_LOAD_RD;
                n_state  = S_LOAD_WR;
            end
            S_LOAD_WR: begin
                o_cmd.op = c8ic_pkg::DP_LOAD_WR;
                n_state  = i_stat.xfer_last ? S_FINISH : S_LOAD_RD;
            end
            S_FINISH: begin
                o_cmd.op = c8ic_pkg::DP_FINISH;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FINISH);
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// ===== rtl/c8ic_dpath.sv =====
// Datapath of the CHIP-8 core: architectural state, memories and execute logic.
module c8ic_dpath #(
    parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  c8ic_pkg::t_dp_cmd  i_cmd,
    input  logic [1:0]         i_cmd_code,
    input  logic [11:0]        i_address,
    input  logic [7:0]         i_write_data,
    input  logic [15:0]        i_key_mask,
    input  logic [7:0]         i_random_byte,
    output c8ic_pkg::t_dp_stat o_stat,
    output logic [7:0]         o_read_value,
    output logic [11:0]        o_program_counter,
    output logic [15:0]        o_executed_opcode,
    output logic               o_waiting_for_key,
    output logic               o_display_changed,
    output logic [1:0]         o_fault
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = $clog2(STACK_DEPTH);

    // latched item
    c8ic_pkg::t_cmd r_cmd;
    logic [11:0]    r_addr;
    logic [7:0]     r_wdata;
    logic [15:0]    r_keys;
    logic [7:0]     r_rnd;

    // architectural state
    logic [11:0]    r_pc;
    logic [11:0]    r_i;
    logic [SPW-1:0] r_sp;
    logic [7:0]     r_dly;

    // per-instruction working registers
    logic [15:0] r_op;
    logic [7:0]  r_vx;
    logic [7:0]  r_vy;
    logic [7:0]  r_res;
    logic [4:0]  r_cnt;
    logic        r_col;
    logic        r_wait;
    logic        r_chg;
    logic [1:0]  r_fault;
    logic [11:0] r_icnt;

    // result registers
    logic [7:0]  r_o_rv;
    logic [11:0] r_o_pc;
    logic [15:0] r_o_op;
    logic        r_o_wait;
    logic        r_o_chg;
    logic [1:0]  r_o_fault;

    // memory ports
    logic        mem_we;
    logic [11:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic [11:0] mem_raddr;
    logic [7:0]  mem_rdata;

    logic                           fb_we;
    logic [c8ic_pkg::ROW_AW-1:0]    fb_waddr;
    logic [c8ic_pkg::SCREEN_WIDTH-1:0] fb_wdata;
    logic [c8ic_pkg::ROW_AW-1:0]    fb_raddr;
    logic [c8ic_pkg::SCREEN_WIDTH-1:0] fb_rdata;

    logic       rf_we;
    logic [3:0] rf_waddr;
    logic [7:0] rf_wdata;
    logic [3:0] rf_raddr;
    logic [7:0] rf_rdata;

    logic           stk_we;
    logic [SIW-1:0] stk_waddr;
    logic [11:0]    stk_wdata;
    logic [SIW-1:0] stk_raddr;
    logic [11:0]    stk_rdata;

    // decoded fields
    logic [3:0]  op_hi;
    logic [3:0]  op_x;
    logic [3:0]  op_y;
    logic [3:0]  op_n;
    logic [7:0]  op_nn;
    logic [11:0] op_nnn;
    logic [5:0]  px;
    logic [4:0]  py;
    logic [11:0] loop_addr;
    logic [4:0]  row_addr;

    // execute results
    logic [11:0]    e_pc;
    logic [11:0]    e_i;
    logic [7:0]     e_res;
    logic           e_wr_vx;
    logic           e_flag_wr;
    logic           e_flag;
    logic [1:0]     e_fault;
    logic           e_wait;
    logic           e_push;
    logic           e_pop;
    logic [7:0]     e_dly;
    logic [8:0]     e_sum;
    logic           e_held;
    logic           e_key_any;
    logic [3:0]     e_key;
    logic [SPW-1:0] sp_dec;

    // sprite row
    logic [7:0]  spr_rev;
    logic [63:0] spr_mask;

    // BCD digits
    logic [7:0] bcd_hund;
    logic [7:0] bcd_rem;
    logic [7:0] bcd_tens;
    logic [7:0] bcd_ones;
    logic [7:0] bcd_digit;

    assign op_hi     = r_op[15:12];
    assign op_x      = r_op[11:8];
    assign op_y      = r_op[7:4];
    assign op_n      = r_op[3:0];
    assign op_nn     = r_op[7:0];
    assign op_nnn    = r_op[11:0];
    assign px        = r_vx[5:0];
    assign py        = r_vy[4:0];
    assign loop_addr = r_i + {7'd0, r_cnt};
    assign row_addr  = py + r_cnt;
    assign sp_dec    = r_sp - SPW'(1);

    c8ic_ram #(
        .WIDTH(8),
        .DEPTH(c8ic_pkg::MEM_DEPTH)
    ) u_main_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    c8ic_ram #(
        .WIDTH(c8ic_pkg::SCREEN_WIDTH),
        .DEPTH(c8ic_pkg::SCREEN_HEIGHT)
    ) u_frame_mem (
        .i_clk  (i_clk),
        .i_we   (fb_we),
        .i_waddr(fb_waddr),
        .i_wdata(fb_wdata),
        .i_raddr(fb_raddr),
        .o_rdata(fb_rdata)
    );

    c8ic_ram #(
        .WIDTH(8),
        .DEPTH(c8ic_pkg::REG_COUNT)
    ) u_reg_file (
        .i_clk  (i_clk),
        .i_we   (rf_we),
        .i_waddr(rf_waddr),
        .i_wdata(rf_wdata),
        .i_raddr(rf_raddr),
        .o_rdata(rf_rdata)
    );

    // return stack; the top entry is read continuously, the pointer only moves in execute
    c8ic_ram #(
        .WIDTH(12),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    assign stk_we    = (i_cmd.op == c8ic_pkg::DP_EXEC) && e_push;
    assign stk_waddr = r_sp[SIW-1:0];
    assign stk_wdata = r_pc + 12'd2;
    assign stk_raddr = sp_dec[SIW-1:0];

    // BCD split by compares against multiples of a hundred and ten, then subtraction
    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_hund = 8'd2;
        end else if (r_vx >= 8'd100) begin
            bcd_hund = 8'd1;
        end else begin
            bcd_hund = 8'd0;
        end
        bcd_rem  = r_vx - 8'(bcd_hund * 8'd100);
        bcd_tens = 8'd0;
        for (int k = 1; k <= 9; k++) begin
            if (bcd_rem >= 8'(k * 10)) bcd_tens = 8'(k);
        end
        bcd_ones = bcd_rem - 8'(bcd_tens * 8'd10);
        unique case (r_cnt[1:0])
            2'd0:    bcd_digit = bcd_hund;
            2'd1:    bcd_digit = bcd_tens;
            default: bcd_digit = bcd_ones;
        endcase
    end

    // sprite byte MSB-first onto the row; bits shifted past the edge drop off
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            spr_rev[c] = mem_rdata[7 - c];
        end
        spr_mask = {56'd0, spr_rev} << px;
    end

    // lowest held key
    always_comb begin
        e_key_any = |r_keys;
        e_key     = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) e_key = 4'(k);
        end
    end

    always_comb begin
        e_pc      = r_pc + 12'd2;
        e_i       = r_i;
        e_res     = 8'd0;
        e_wr_vx   = 1'b0;
        e_flag_wr = 1'b0;
        e_flag    = 1'b0;
        e_fault   = c8ic_pkg::FAULT_NONE;
        e_wait    = 1'b0;
        e_push    = 1'b0;
        e_pop     = 1'b0;
        e_dly     = r_dly;
        e_sum     = {1'b0, r_vx} + {1'b0, r_vy};
        e_held    = r_keys[r_vx[3:0]];
        unique case (op_hi)
            4'h0: begin
                if (r_op == c8ic_pkg::OP_RET) begin
                    if (r_sp == '0) begin
                        e_pc    = 12'd0;
                        e_fault = c8ic_pkg::FAULT_UNDER;
                    end else begin
                        e_pop = 1'b1;
                        e_pc  = stk_rdata;
                    end
                end
            end
            4'h1: e_pc = op_nnn;
            4'h2: begin
                if (r_sp >= SPW'(STACK_DEPTH)) begin
                    e_fault = c8ic_pkg::FAULT_OVER;
                end else begin
                    e_push = 1'b1;
                end
                e_pc = op_nnn;
            end
            4'h3: if (r_vx == op_nn) e_pc = r_pc + 12'd4;
            4'h4: if (r_vx != op_nn) e_pc = r_pc + 12'd4;
            4'h5: if (r_vx == r_vy) e_pc = r_pc + 12'd4;
            4'h6: begin
                e_res   = op_nn;
                e_wr_vx = 1'b1;
            end
            4'h7: begin
                e_res   = r_vx + op_nn;
                e_wr_vx = 1'b1;
            end
            4'h8: begin
                e_wr_vx = 1'b1;
                unique case (op_n)
                    4'h0: e_res = r_vy;
                    4'h1: e_res = r_vx | r_vy;
                    4'h2: e_res = r_vx & r_vy;
                    4'h3: e_res = r_vx ^ r_vy;
                    4'h4: begin
                        e_res     = e_sum[7:0];
                        e_flag    = e_sum[8];
                        e_flag_wr = 1'b1;
                    end
                    4'h5: begin
                        e_res     = r_vx - r_vy;
                        e_flag    = (r_vx >= r_vy);
                        e_flag_wr = 1'b1;
                    end
                    4'h6: begin
                        e_res     = {1'b0, r_vx[7:1]};
                        e_flag    = r_vx[0];
                        e_flag_wr = 1'b1;
                    end
                    4'h7: begin
                        e_res     = r_vy - r_vx;
                        e_flag    = (r_vy >= r_vx);
                        e_flag_wr = 1'b1;
                    end
                    4'hE: begin
                        e_res     = {r_vx[6:0], 1'b0};
                        e_flag    = r_vx[7];
                        e_flag_wr = 1'b1;
                    end
                    default: e_wr_vx = 1'b0;
                endcase
            end
            4'h9: if (r_vx != r_vy) e_pc = r_pc + 12'd4;
            4'hA: e_i = op_nnn;
            // register file read data holds V0 here
            4'hB: e_pc = {4'd0, rf_rdata} + op_nnn;
            4'hC: begin
                e_res   = r_rnd & op_nn;
                e_wr_vx = 1'b1;
            end
            4'hD: ;
            4'hE: begin
                if ((op_nn == c8ic_pkg::NN_SKP && e_held)
                        || (op_nn == c8ic_pkg::NN_SKNP && !e_held)) begin
                    e_pc = r_pc + 12'd4;
                end
            end
            default: begin
                unique case (op_nn)
                    c8ic_pkg::NN_GET_DLY: begin
                        e_res   = r_dly;
                        e_wr_vx = 1'b1;
                    end
                    c8ic_pkg::NN_KEY_WAIT: begin
                        if (e_key_any) begin
                            e_res   = {4'd0, e_key};
                            e_wr_vx = 1'b1;
                        end else begin
                            e_pc   = r_pc;
                            e_wait = 1'b1;
                        end
                    end
                    c8ic_pkg::NN_SET_DLY: e_dly = r_vx;
                    c8ic_pkg::NN_ADD_I:   e_i = r_i + {4'd0, r_vx};
                    c8ic_pkg::NN_FONT:
                        e_i = c8ic_pkg::FONT_BASE + {2'd0, r_vx, 2'd0} + {4'd0, r_vx};
                    default: ;
                endcase
            end
        endcase
    end

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = loop_addr;
        mem_wdata = bcd_digit;
        mem_raddr = r_pc;
        fb_we     = 1'b0;
        fb_waddr  = row_addr;
        fb_wdata  = '0;
        fb_raddr  = row_addr;
        rf_we     = 1'b0;
        rf_waddr  = op_x;
        rf_wdata  = r_res;
        rf_raddr  = r_cnt[3:0];
        unique case (i_cmd.op)
            c8ic_pkg::DP_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_icnt;
                mem_wdata = c8ic_pkg::init_byte(r_icnt);
                fb_we     = (r_icnt[11:5] == '0);
                fb_waddr  = r_icnt[4:0];
                rf_we     = (r_icnt[11:4] == '0);
                rf_waddr  = r_icnt[3:0];
                rf_wdata  = 8'd0;
            end
            c8ic_pkg::DP_ACCESS: begin
                mem_we    = (r_cmd == c8ic_pkg::CMD_WRITE);
                mem_waddr = r_addr;
                mem_wdata = r_wdata;
                mem_raddr = r_addr;
                fb_raddr  = r_addr[10:6];
            end
            c8ic_pkg::DP_FETCH1: mem_raddr = r_pc + 12'd1;
            c8ic_pkg::DP_FETCH2: rf_raddr = op_x;
            c8ic_pkg::DP_RDX:    rf_raddr = op_y;
            c8ic_pkg::DP_RDY:    rf_raddr = 4'd0;
            c8ic_pkg::DP_EXEC: begin
                rf_we    = e_flag_wr;
                rf_waddr = 4'hF;
                rf_wdata = {7'd0, e_flag};
            end
            c8ic_pkg::DP_WB: rf_we = 1'b1;
            c8ic_pkg::DP_CLS: begin
                fb_we    = 1'b1;
                fb_waddr = r_cnt;
            end
            c8ic_pkg::DP_SPR_RD: mem_raddr = loop_addr;
            c8ic_pkg::DP_SPR_WR: begin
                fb_we    = 1'b1;
                fb_wdata = fb_rdata ^ spr_mask;
            end
            c8ic_pkg::DP_SPR_FLAG: begin
                rf_we    = 1'b1;
                rf_waddr = 4'hF;
                rf_wdata = {7'd0, r_col};
            end
            c8ic_pkg::DP_BCD: mem_we = 1'b1;
            c8ic_pkg::DP_DUMP_WR: begin
                mem_we    = 1'b1;
                mem_wdata = rf_rdata;
            end
            c8ic_pkg::DP_LOAD_RD: mem_raddr = loop_addr;
            c8ic_pkg::DP_LOAD_WR: begin
                rf_we    = 1'b1;
                rf_waddr = r_cnt[3:0];
                rf_wdata = mem_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= c8ic_pkg::PROG_START;
            r_i    <= 12'd0;
            r_sp   <= '0;
            r_dly  <= 8'd0;
            r_icnt <= 12'd0;
        end else begin
            unique case (i_cmd.op)
                c8ic_pkg::DP_INIT: r_icnt <= r_icnt + 12'd1;
                c8ic_pkg::DP_EXEC: begin
                    r_pc  <= e_pc;
                    r_i   <= e_i;
                    r_dly <= e_dly;
                    if (e_push) begin
                        r_sp <= r_sp + SPW'(1);
                    end else if (e_pop) begin
                        r_sp <= sp_dec;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd   <= c8ic_pkg::t_cmd'(i_cmd_code);
            r_addr  <= i_address;
            r_wdata <= i_write_data;
            r_keys  <= i_key_mask;
            r_rnd   <= i_random_byte;
            r_op    <= 16'd0;
            r_wait  <= 1'b0;
            r_chg   <= 1'b0;
            r_fault <= c8ic_pkg::FAULT_NONE;
        end
        unique case (i_cmd.op)
            c8ic_pkg::DP_FETCH1: r_op[15:8] <= mem_rdata;
            c8ic_pkg::DP_FETCH2: r_op[7:0]  <= mem_rdata;
            c8ic_pkg::DP_RDX:    r_vx <= rf_rdata;
            c8ic_pkg::DP_RDY:    r_vy <= rf_rdata;
            c8ic_pkg::DP_EXEC: begin
                r_res   <= e_res;
                r_fault <= e_fault;
                r_wait  <= e_wait;
                r_chg   <= (r_op == c8ic_pkg::OP_CLS) || (op_hi == 4'hD);
                r_cnt   <= 5'd0;
                r_col   <= 1'b0;
            end
            c8ic_pkg::DP_SPR_WR: begin
                r_col <= r_col | (|(fb_rdata & spr_mask));
                r_cnt <= r_cnt + 5'd1;
            end
            c8ic_pkg::DP_CLS,
            c8ic_pkg::DP_BCD,
            c8ic_pkg::DP_DUMP_WR,
            c8ic_pkg::DP_LOAD_WR: r_cnt <= r_cnt + 5'd1;
            c8ic_pkg::DP_FINISH: begin
                unique case (r_cmd)
                    c8ic_pkg::CMD_READ:  r_o_rv <= mem_rdata;
                    c8ic_pkg::CMD_PIXEL: r_o_rv <= r_addr[11] ? 8'd0 : {7'd0, fb_rdata[r_addr[5:0]]};
                    default:             r_o_rv <= 8'd0;
                endcase
                r_o_pc    <= r_pc;
                r_o_op    <= r_op;
                r_o_wait  <= r_wait;
                r_o_chg   <= r_chg;
                r_o_fault <= r_fault;
            end
            default: ;
        endcase
    end

    assign o_stat.init_last  = (r_icnt == 12'hFFF);
    assign o_stat.cmd_exec   = (r_cmd == c8ic_pkg::CMD_EXEC);
    assign o_stat.wr_vx      = e_wr_vx;
    assign o_stat.is_cls     = (r_op == c8ic_pkg::OP_CLS);
    assign o_stat.is_draw    = (op_hi == 4'hD);
    assign o_stat.draw_empty = (op_n == 4'd0);
    assign o_stat.is_bcd     = (op_hi == 4'hF) && (op_nn == c8ic_pkg::NN_BCD);
    assign o_stat.is_dump    = (op_hi == 4'hF) && (op_nn == c8ic_pkg::NN_DUMP);
    assign o_stat.is_load    = (op_hi == 4'hF) && (op_nn == c8ic_pkg::NN_LOAD);
    assign o_stat.cls_last   = (r_cnt == 5'd31);
    assign o_stat.spr_last   = (r_cnt + 5'd1 == {1'b0, op_n})
                             || (({1'b0, py} + {1'b0, r_cnt}) == 6'd31);
    assign o_stat.bcd_last   = (r_cnt == 5'd2);
    assign o_stat.xfer_last  = (r_cnt == {1'b0, op_x});

    assign o_read_value      = r_o_rv;
    assign o_program_counter = r_o_pc;
    assign o_executed_opcode = r_o_op;
    assign o_waiting_for_key = r_o_wait;
    assign o_display_changed = r_o_chg;
    assign o_fault           = r_o_fault;

endmodule

// ===== rtl/chip8_instruction_core.sv =====
// Top level of the CHIP-8 instruction core: sequencer plus datapath.
//
// Raise start with a command while busy is low; the item is taken on that edge and its
// result appears for exactly one cycle with o_done, which cannot be held off. After reset
// the core runs an initialization pass over main memory (font, frame buffer and registers)
// with busy high. Memory write, memory read and pixel read pass through access and finish;
// execute adds fetch, operand reads and execute, plus a write-back when a register is
// written; screen clear, sprite draw, BCD and register dump or load then walk one row,
// digit or byte per step. Busy drops in the result cycle, so the next item can be taken
// on the edge that ends it.
module chip8_instruction_core #(
    parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_key_mask,
    input  logic [7:0]  i_random_byte,
    output logic        o_done,
    output logic [7:0]  o_read_value,
    output logic [11:0] o_program_counter,
    output logic [15:0] o_executed_opcode,
    output logic        o_waiting_for_key,
    output logic        o_display_changed,
    output logic [1:0]  o_fault
);

    c8ic_pkg::t_dp_cmd  dp_cmd;
    c8ic_pkg::t_dp_stat dp_stat;

    c8ic_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (dp_stat),
        .o_cmd  (dp_cmd),
        .o_busy (busy),
        .o_done (o_done)
    );

    c8ic_dpath #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_cmd_code       (i_cmd),
        .i_address        (i_address),
        .i_write_data     (i_write_data),
        .i_key_mask       (i_key_mask),
        .i_random_byte    (i_random_byte),
        .o_stat           (dp_stat),
        .o_read_value     (o_read_value),
        .o_program_counter(o_program_counter),
        .o_executed_opcode(o_executed_opcode),
        .o_waiting_for_key(o_waiting_for_key),
        .o_display_changed(o_display_changed),
        .o_fault          (o_fault)
    );

endmodule

// ===== rtl/c8ic_checker.sv =====
// Port-level checks of the CHIP-8 core and their binding to the top level.
`include "chip8_instruction_core_defines.svh"

module c8ic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_cmd,
    input logic [11:0] i_address,
    input logic [7:0]  i_write_data,
    input logic [15:0] i_key_mask,
    input logic [7:0]  i_random_byte,
    input logic        o_done,
    input logic [7:0]  o_read_value,
    input logic [11:0] o_program_counter,
    input logic [15:0] o_executed_opcode,
    input logic        o_waiting_for_key,
    input logic        o_display_changed,
    input logic [1:0]  o_fault
);

    // an accepted item keeps the core busy on the next cycle
    `C8IC_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // a result is only shown once the core is free again
    `C8IC_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy)

    `C8IC_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)

    // underflow comes only from a return and lands at address zero
    `C8IC_ASSERT_IMP(a_underflow, i_clk, i_rst_n, o_done && o_fault == c8ic_pkg::FAULT_UNDER,
        o_executed_opcode == c8ic_pkg::OP_RET && o_program_counter == 12'd0)

endmodule

bind chip8_instruction_core c8ic_checker u_c8ic_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the CHIP-8 instruction core, with its own predictor.
`timescale 1ns / 100ps

module testbench;
    import c8ic_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SDEPTH       = STACK_DEPTH_DEF;

    typedef struct {
        logic [7:0]  rv;
        logic [11:0] pc;
        logic [15:0] op;
        logic        key_wait;
        logic        chg;
        logic [1:0]  flt;
    } core_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [11:0] i_address;
    logic [7:0]  i_write_data;
    logic [15:0] i_key_mask;
    logic [7:0]  i_random_byte;
    logic        o_done;
    logic [7:0]  o_read_value;
    logic [11:0] o_program_counter;
    logic [15:0] o_executed_opcode;
    logic        o_waiting_for_key;
    logic        o_display_changed;
    logic [1:0]  o_fault;

    chip8_instruction_core uut (.*);

    // Shadow copy of the core state
    logic [7:0]  sh_mem [MEM_DEPTH];
    bit          sh_fb [SCREEN_WIDTH * SCREEN_HEIGHT];
    logic [7:0]  sh_v [16];
    logic [11:0] sh_stk [SDEPTH];
    int          sh_sp;
    logic [11:0] sh_idx;
    logic [11:0] sh_pc;
    logic [7:0]  sh_dly;
    logic [7:0]  sh_snd;

    core_result_t expected_results[$];
    int           errors;
    int           cycles;
    bit           burst_mode;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        core_result_t e;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report("unexpected result", o_program_counter, 0);
            end else begin
                e = expected_results.pop_front();
                if (o_read_value !== e.rv)
                    report("read_value", o_read_value, e.rv);
                if (o_program_counter !== e.pc)
                    report("program_counter", o_program_counter, e.pc);
                if (o_executed_opcode !== e.op)
                    report("executed_opcode", o_executed_opcode, e.op);
                if (o_waiting_for_key !== e.key_wait)
                    report("waiting_for_key", o_waiting_for_key, e.key_wait);
                if (o_display_changed !== e.chg)
                    report("display_changed", o_display_changed, e.chg);
                if (o_fault !== e.flt)
                    report("fault", o_fault, e.flt);
            end
        end
    end

    function automatic void shadow_reset();
        for (int a = 0; a < MEM_DEPTH; a++) sh_mem[a] = 8'h00;
        for (int a = 0; a < 80; a++) sh_mem[FONT_BASE + a] = FONT[a];
        for (int a = 0; a < SCREEN_WIDTH * SCREEN_HEIGHT; a++) sh_fb[a] = 1'b0;
        for (int a = 0; a < 16; a++) sh_v[a] = 8'h00;
        for (int a = 0; a < SDEPTH; a++) sh_stk[a] = 12'h000;
        sh_sp  = 0;
        sh_idx = 12'h000;
        sh_pc  = PROG_START;
        sh_dly = 8'h00;
        sh_snd = 8'h00;
    endfunction

    // Run one instruction on the shadow state
    function automatic void chip8_execute(input logic [15:0] keys, input logic [7:0] rnd,
                                          inout core_result_t r);
        logic [15:0] op;
        logic [11:0] nnn;
        logic [7:0]  nn, a, b, row;
        logic [3:0]  x, y, n;
        logic [8:0]  sum;
        logic [11:0] ad;
        int          px, py, p;
        bit          found;
        op  = {sh_mem[sh_pc], sh_mem[sh_pc + 12'd1]};
        nnn = op[11:0];
        nn  = op[7:0];
        n   = op[3:0];
        x   = op[11:8];
        y   = op[7:4];
        r.op = op;
        sh_pc = sh_pc + 12'd2;
        case (op[15:12])
            4'h0: begin
                if (op == OP_CLS) begin
                    for (int i = 0; i < SCREEN_WIDTH * SCREEN_HEIGHT; i++) sh_fb[i] = 1'b0;
                    r.chg = 1'b1;
                end else if (op == OP_RET) begin
                    if (sh_sp == 0) begin
                        sh_pc = 12'h000;
                        r.flt = FAULT_UNDER;
                    end else begin
                        sh_sp--;
                        sh_pc = sh_stk[sh_sp];
                    end
                end
            end
            4'h1: sh_pc = nnn;
            4'h2: begin
                if (sh_sp >= SDEPTH) begin
                    r.flt = FAULT_OVER;
                end else begin
                    sh_stk[sh_sp] = sh_pc;
                    sh_sp++;
                end
                sh_pc = nnn;
            end
            4'h3: if (sh_v[x] == nn) sh_pc = sh_pc + 12'd2;
            4'h4: if (sh_v[x] != nn) sh_pc = sh_pc + 12'd2;
            4'h5: if (sh_v[x] == sh_v[y]) sh_pc = sh_pc + 12'd2;
            4'h6: sh_v[x] = nn;
            4'h7: sh_v[x] = sh_v[x] + nn;
            4'h8: begin
                a = sh_v[x];
                b = sh_v[y];
                sum = {1'b0, a} + {1'b0, b};
                // VF first, then Vx, so X=F keeps the arithmetic value
                case (n)
                    4'h0: sh_v[x] = b;
                    4'h1: sh_v[x] = a | b;
                    4'h2: sh_v[x] = a & b;
                    4'h3: sh_v[x] = a ^ b;
                    4'h4: begin sh_v[15] = {7'd0, sum[8]}; sh_v[x] = sum[7:0]; end
                    4'h5: begin sh_v[15] = {7'd0, a >= b}; sh_v[x] = a - b; end
                    4'h6: begin sh_v[15] = {7'd0, a[0]}; sh_v[x] = a >> 1; end
                    4'h7: begin sh_v[15] = {7'd0, b >= a}; sh_v[x] = b - a; end
                    4'hE: begin sh_v[15] = {7'd0, a[7]}; sh_v[x] = a << 1; end
                    default: ;
                endcase
            end
            4'h9: if (sh_v[x] != sh_v[y]) sh_pc = sh_pc + 12'd2;
            4'hA: sh_idx = nnn;
            4'hB: sh_pc = {4'd0, sh_v[0]} + nnn;
            4'hC: sh_v[x] = rnd & nn;
            4'hD: begin
                px = sh_v[x] % SCREEN_WIDTH;
                py = sh_v[y] % SCREEN_HEIGHT;
                sh_v[15] = 8'h00;
                r.chg = 1'b1;
                for (int rr = 0; rr < n && py + rr < SCREEN_HEIGHT; rr++) begin
                    row = sh_mem[sh_idx + 12'(rr)];
                    for (int c = 0; c < 8 && px + c < SCREEN_WIDTH; c++) begin
                        if (row[7 - c]) begin
                            p = (py + rr) * SCREEN_WIDTH + px + c;
                            if (sh_fb[p]) sh_v[15] = 8'h01;
                            sh_fb[p] = ~sh_fb[p];
                        end
                    end
                end
            end
            4'hE: begin
                if ((nn == NN_SKP && keys[sh_v[x][3:0]]) || (nn == NN_SKNP && !keys[sh_v[x][3:0]]))
                    sh_pc = sh_pc + 12'd2;
            end
            default: begin
                case (nn)
                    NN_GET_DLY: sh_v[x] = sh_dly;
                    NN_KEY_WAIT: begin
                        found = 1'b0;
                        for (int i = 0; i < 16; i++) begin
                            if (!found && keys[i]) begin
                                sh_v[x] = 8'(i);
                                found = 1'b1;
                            end
                        end
                        if (!found) begin
                            sh_pc = sh_pc - 12'd2;
                            r.key_wait = 1'b1;
                        end
                    end
                    NN_SET_DLY: sh_dly = sh_v[x];
                    NN_SET_SND: sh_snd = sh_v[x];
                    NN_ADD_I:   sh_idx = sh_idx + {4'd0, sh_v[x]};
                    NN_FONT:    sh_idx = FONT_BASE + 12'(sh_v[x] * 5);
                    NN_BCD: begin
                        sh_mem[sh_idx]         = sh_v[x] / 100;
                        sh_mem[sh_idx + 12'd1] = (sh_v[x] / 10) % 10;
                        sh_mem[sh_idx + 12'd2] = sh_v[x] % 10;
                    end
                    NN_DUMP: begin
                        for (int i = 0; i <= x; i++) begin
                            ad = sh_idx + 12'(i);
                            sh_mem[ad] = sh_v[i];
                        end
                    end
                    NN_LOAD: begin
                        for (int i = 0; i <= x; i++) begin
                            ad = sh_idx + 12'(i);
                            sh_v[i] = sh_mem[ad];
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    endfunction

    function automatic core_result_t chip8_predict(input t_cmd cmd, input logic [11:0] addr,
                                                   input logic [7:0] wd, input logic [15:0] keys,
                                                   input logic [7:0] rnd);
        core_result_t r;
        r = '{rv: 8'h00, pc: 12'h000, op: 16'h0000, key_wait: 1'b0, chg: 1'b0, flt: FAULT_NONE};
        case (cmd)
            CMD_WRITE: sh_mem[addr] = wd;
            CMD_READ:  r.rv = sh_mem[addr];
            CMD_PIXEL: r.rv = (addr < SCREEN_WIDTH * SCREEN_HEIGHT) ? {7'd0, sh_fb[addr]} : 8'h00;
            default:   chip8_execute(keys, rnd, r);
        endcase
        r.pc = sh_pc;
        return r;
    endfunction

    // Caller stands at a rising edge; returns at the edge that took the item, or after a random idle gap with start low
    task automatic send_item(input t_cmd cmd, input logic [11:0] addr, input logic [7:0] wd,
                             input logic [15:0] keys, input logic [7:0] rnd);
        int gap;
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_address     <= addr;
        i_write_data  <= wd;
        i_key_mask    <= keys;
        i_random_byte <= rnd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_results.push_back(chip8_predict(cmd, addr, wd, keys, rnd));
        gap = 0;
        if (!burst_mode)
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] rand_keys();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom());
        endcase
    endfunction

    // Place an instruction at the counter, then run it
    task automatic run_op(input logic [15:0] op, input logic [15:0] keys);
        send_item(CMD_WRITE, sh_pc, op[15:8], 16'($urandom()), 8'($urandom()));
        send_item(CMD_WRITE, sh_pc + 12'd1, op[7:0], 16'($urandom()), 8'($urandom()));
        send_item(CMD_EXEC, 12'($urandom()), 8'($urandom()), keys, 8'($urandom()));
    endtask

    function automatic logic [15:0] rand_op();
        logic [3:0] fam;
        logic [3:0] x;
        logic [7:0] fnn [11];
        fnn = '{NN_GET_DLY, NN_KEY_WAIT, NN_SET_DLY, NN_SET_SND, NN_ADD_I, NN_FONT,
                NN_BCD, NN_DUMP, NN_LOAD, NN_SKP, NN_SKNP};
        fam = 4'($urandom());
        x = 4'($urandom());
        case (fam)
            4'h0: begin
                case ($urandom_range(0, 3))
                    0:       return OP_CLS;
                    1, 2:    return OP_RET;
                    default: return {4'h0, 12'($urandom())};
                endcase
            end
            4'h8: begin
                if ($urandom_range(0, 7) == 0) return {4'h8, 12'($urandom())};
                return {4'h8, x, 4'($urandom()), 4'($urandom_range(0, 7))};
            end
            4'hD: begin
                if ($urandom_range(0, 3) == 0) return {4'hD, 12'($urandom())};
                return {4'hD, 8'($urandom()), 4'($urandom_range(0, 5))};
            end
            4'hE: begin
                if ($urandom_range(0, 5) == 0) return {4'hE, 12'($urandom())};
                return {4'hE, x, ($urandom_range(0, 1) ? NN_SKP : NN_SKNP)};
            end
            4'hF: begin
                if ($urandom_range(0, 7) == 0) return {4'hF, 12'($urandom())};
                return {4'hF, x, fnn[$urandom_range(0, 8)]};
            end
            default: return {fam, 12'($urandom())};
        endcase
    endfunction

    task automatic test_memory();
        send_item(CMD_WRITE, 12'h000, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(CMD_WRITE, 12'hFFF, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_READ, 12'h000, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_READ, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(CMD_READ, FONT_BASE, 8'h00, 16'h0000, 8'h00);
    endtask

    task automatic test_pixels();
        send_item(CMD_PIXEL, 12'd0, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_PIXEL, 12'd2047, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_PIXEL, 12'd2048, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_PIXEL, 12'hFFF, 8'h00, 16'h0000, 8'h00);
    endtask

    task automatic test_special_ops();
        run_op(OP_RET, 16'h0000);                  // return with empty stack
        run_op({4'hF, 4'h3, NN_KEY_WAIT}, 16'h0000); // no key held: re-execute
        run_op({4'hF, 4'h3, NN_KEY_WAIT}, 16'h8000);
        run_op(16'h6FFF, 16'h0000);
        run_op(16'hDFF8, 16'h0000);                 // draw clipped at both edges
        run_op(16'h8FF5, 16'h0000);                 // equal operands, result lands in VF
    endtask

    task automatic test_random();
        int items;
        items = 0;
        while (items < 1200) begin
            burst_mode = ($urandom_range(0, 15) == 0);
            case ($urandom_range(0, 15))
                0: begin
                    send_item(CMD_WRITE, 12'($urandom()), 8'($urandom()), rand_keys(),
                              8'($urandom()));
                    items++;
                end
                1: begin
                    send_item(CMD_READ, 12'($urandom()), 8'($urandom()), rand_keys(),
                              8'($urandom()));
                    items++;
                end
                2: begin
                    send_item(CMD_PIXEL, ($urandom_range(0, 7) == 0) ? 12'($urandom())
                              : 12'($urandom_range(0, 2047)), 8'($urandom()), rand_keys(),
                              8'($urandom()));
                    items++;
                end
                3: begin
                    // run whatever lies at the counter
                    send_item(CMD_EXEC, 12'($urandom()), 8'($urandom()), rand_keys(),
                              8'($urandom()));
                    items++;
                end
                4: begin
                    // chain of calls, at times deep enough to overflow the stack
                    for (int k = $urandom_range(1, SDEPTH + 3); k > 0; k--) begin
                        run_op({4'h2, 12'($urandom())}, rand_keys());
                        items += 3;
                    end
                end
                default: begin
                    run_op(rand_op(), rand_keys());
                    items += 3;
                end
            endcase
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        errors     = 0;
        cycles     = 0;
        burst_mode = 1'b0;
        shadow_reset();
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cmd         = CMD_WRITE;
        i_address     = 12'h000;
        i_write_data  = 8'h00;
        i_key_mask    = 16'h0000;
        i_random_byte = 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_memory();
        test_pixels();
        test_special_ops();
        test_random();

        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
